// ----- rtl/core/gost_pkg.sv -----
// Shared types, S-box table and round function for the GOST block cipher.
`default_nettype none

package gost_pkg;

    localparam int KeyWords  = 8;
    localparam int Rounds    = 32;
    localparam int RotLeft   = 11;
    localparam int AddrBits  = 5;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] block_low;
        logic [31:0] block_high;
    } t_blk_in;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
    } t_blk_out;

    // One pipeline slot; a is the half that the next round feeds through f.
    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
    } t_stage;

    // Row n serves nibble n (bits 4n+3..4n).
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7}
    };

    function automatic logic [31:0] round_f(input logic [31:0] half, input logic [31:0] kw);
        logic [31:0] sum;
        logic [31:0] sub;
        sum = half + kw;
        for (int n = 0; n < 8; n++) begin
            sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
        end
        return {sub[31-RotLeft:0], sub[31:32-RotLeft]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gost_round.sv -----
// One registered Feistel round of the GOST pipeline.
`default_nettype none

module gost_round (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gost_pkg::t_stage i_stage,
    input  wire logic [31:0]     i_key_enc,
    input  wire logic [31:0]     i_key_dec,
    output gost_pkg::t_stage     o_stage
);

    gost_pkg::t_stage r_stage;
    gost_pkg::t_stage n_stage;
    logic [31:0]      key;

    always_comb begin
        key = (i_stage.op == gost_pkg::OP_DECRYPT) ? i_key_dec : i_key_enc;
        // halves trade places every round so the updated one is always 'a'
        n_stage.valid = i_stage.valid;
        n_stage.op    = i_stage.op;
        n_stage.a     = i_stage.b ^ gost_pkg::round_f(i_stage.a, key);
        n_stage.b     = i_stage.a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.op <= n_stage.op;
        r_stage.a  <= n_stage.a;
        r_stage.b  <= n_stage.b;
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- rtl/core/gost_block_cipher_ecb.sv -----
// A block passes one register per round between its start transfer and its o_valid strobe.
// Throughput: one block per cycle while busy is low; the 32 round stages never stall.
// busy is high during reset and until the first clock edge that samples reset released, low from then on.
// Reset (synchronous, active low) clears all key words to zero and drops every
// in-flight block; no result strobe follows a block that was in the pipeline.
`default_nettype none

module gost_block_cipher_ecb (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire gost_pkg::t_blk_in                 i_data,
    output logic                                   o_valid,
    output gost_pkg::t_blk_out                     o_result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gost_pkg::AddrBits-1:0]     paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    logic [31:0]      r_key [gost_pkg::KeyWords];
    logic             r_busy;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    gost_pkg::t_stage w_stage [gost_pkg::Rounds+1];

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[gost_pkg::AddrBits-1:2];
    assign prdata  = r_key[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gost_pkg::KeyWords; k++) begin
                r_key[k] <= '0;
            end
        end else if (cfg_wr) begin
            r_key[cfg_idx] <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    always_comb begin
        w_stage[0].valid = start && !r_busy;
        w_stage[0].op    = i_data.operation;
        w_stage[0].a     = i_data.block_low;
        w_stage[0].b     = i_data.block_high;
    end

    for (genvar g = 0; g < gost_pkg::Rounds; g++) begin : g_round
        // encrypt: 0..7 three times, then 7..0; decrypt: 0..7, then 7..0 three times
        localparam int EncIdx = (g < 24) ? (g % 8) : (7 - (g % 8));
        localparam int DecIdx = (g < 8)  ? g       : (7 - (g % 8));

        gost_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_stage   (w_stage[g]),
            .i_key_enc (r_key[EncIdx]),
            .i_key_dec (r_key[DecIdx]),
            .o_stage   (w_stage[g+1])
        );
    end

    // last round updates n1, so a = n1 and b = n2; output is the swapped pair
    assign o_valid              = w_stage[gost_pkg::Rounds].valid;
    assign o_result.result_low  = w_stage[gost_pkg::Rounds].b;
    assign o_result.result_high = w_stage[gost_pkg::Rounds].a;

endmodule

`default_nettype wire

// ----- rtl/core/gost_chk.sv -----
// Port-level checker for the GOST cipher block, bound to the top level.
`default_nettype none

module gost_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          o_valid,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gost_pkg::AddrBits-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    input  wire logic [31:0]                   prdata,
    input  wire logic                          pready
);

    // every transfer produces exactly one result at the end of the round pipeline
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##32 o_valid)
        else $error("missing result 32 cycles after a start transfer");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 32))
        else $error("result strobe without a matching start transfer");

    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && busy))
        else $error("pipeline not flushed or busy low after reset");

    a_key_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) ##1
        (paddr[gost_pkg::AddrBits-1:2] == $past(paddr[gost_pkg::AddrBits-1:2]))
        |-> (prdata == $past(pwdata)))
        else $error("key word read back differs from the last write");

endmodule

bind gost_block_cipher_ecb gost_chk u_gost_chk (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the GOST 28147-89 ECB block cipher core.
`timescale 1ns / 1ps

module tb_top;

    localparam int IdleLimit    = 2000;
    localparam int DrainCycles  = 40;
    localparam int RandomPerKey = 220;
    localparam int KeyPlans     = 6;
    localparam int DirectedRows = 12;
    localparam int MaxReports   = 10;

    // Substitution rows, row n serves nibble n; entry v of row n sits at
    // bits 511-64n-4v down to 508-64n-4v.
    localparam logic [511:0] SUBST = {
        64'hD2846FB1A93E50C7, 64'h4B2EF08D3C975A61,
        64'hC1AF92680D34E75B, 64'h2C417AB6853FD0E9,
        64'h7DE3069A1285BC4F, 64'hA09E63F51DC7B428,
        64'hF18E6B34972DC05A, 64'hE4D12FB83A6C5907
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    gost_pkg::t_blk_in             i_data;
    logic                          o_valid;
    gost_pkg::t_blk_out            o_result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gost_pkg::AddrBits-1:0] paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    logic [31:0]        key_words [gost_pkg::KeyWords];
    logic [31:0]        key_plan [gost_pkg::KeyWords];
    gost_pkg::t_blk_out pending_blocks [$];
    int unsigned        blocks_sent;
    int unsigned        results_seen;
    int unsigned        mismatches;
    int unsigned        idle_cycles;

    gost_block_cipher_ecb dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] gost_f(input logic [31:0] half, input logic [31:0] kw);
        logic [31:0] sum;
        logic [31:0] sub;
        sum = half + kw;
        for (int n = 0; n < 8; n++) begin
            sub[4*n +: 4] = SUBST[511 - 64*n - 4*sum[4*n +: 4] -: 4];
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    // Encrypt: words 0..7 three times, then 7..0. Decrypt: 0..7 once, then 7..0 three times.
    function automatic int key_slot(input int rnd, input logic decrypt);
        if (decrypt)
            return (rnd < 8) ? rnd : 7 - (rnd % 8);
        return (rnd < 24) ? rnd % 8 : 7 - (rnd % 8);
    endfunction

    function automatic gost_pkg::t_blk_out gost_crypt(input gost_pkg::t_blk_in blk);
        logic [31:0]        n1;
        logic [31:0]        n2;
        logic               decrypt;
        gost_pkg::t_blk_out res;
        n1 = blk.block_low;
        n2 = blk.block_high;
        decrypt = (blk.operation == gost_pkg::OP_DECRYPT);
        for (int r = 0; r < gost_pkg::Rounds; r++) begin
            if (r % 2 == 0)
                n2 = n2 ^ gost_f(n1, key_words[key_slot(r, decrypt)]);
            else
                n1 = n1 ^ gost_f(n2, key_words[key_slot(r, decrypt)]);
        end
        res.result_low  = n2;
        res.result_high = n1;
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endfunction

    function automatic logic [31:0] rand_half();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic gost_pkg::t_blk_in directed_row(input int idx);
        case (idx)
            0:  return {gost_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000};
            1:  return {gost_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000};
            2:  return {gost_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            3:  return {gost_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            4:  return {gost_pkg::OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF};
            5:  return {gost_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000};
            6:  return {gost_pkg::OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA};
            7:  return {gost_pkg::OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555};
            8:  return {gost_pkg::OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000};
            9:  return {gost_pkg::OP_DECRYPT, 32'h8000_0000, 32'h0000_0001};
            10: return {gost_pkg::OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF};
            default: return {gost_pkg::OP_DECRYPT, 32'hFEDC_BA98, 32'h7654_3210};
        endcase
    endfunction

    // Result checking; the prediction is taken with the key held at transfer time.
    always @(posedge i_clk) begin : result_check
        gost_pkg::t_blk_out want;
        if (i_rst_n && start && !busy)
            pending_blocks.push_back(gost_crypt(i_data));
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_blocks.size() == 0) begin
                note_mismatch("result with none pending", 32'h0, o_result.result_low);
            end else begin
                want = pending_blocks.pop_front();
                if (o_result.result_low !== want.result_low)
                    note_mismatch("result_low", want.result_low, o_result.result_low);
                if (o_result.result_high !== want.result_high)
                    note_mismatch("result_high", want.result_high, o_result.result_high);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // psel stays high across back-to-back transfers; apb_idle drops it.
    task automatic write_key(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gost_pkg::AddrBits'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        key_words[idx] = value;
    endtask

    task automatic check_key(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= gost_pkg::AddrBits'(4 * idx);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== key_words[idx])
            note_mismatch("key readback", key_words[idx], prdata);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_keys();
        for (int k = 0; k < gost_pkg::KeyWords; k++) write_key(k, key_plan[k]);
        for (int k = 0; k < gost_pkg::KeyWords; k++) check_key(k);
        apb_idle();
    endtask

    // Returns in the time step of the edge that took the transfer.
    task automatic push_block(input gost_pkg::t_blk_in blk, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= blk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        blocks_sent++;
    endtask

    task automatic finish_batch();
        start <= 1'b0;
        while (results_seen < blocks_sent) @(posedge i_clk);
    endtask

    task automatic run_directed();
        for (int i = 0; i < DirectedRows; i++) push_block(directed_row(i), pick_gap());
        finish_batch();
    endtask

    task automatic run_random(input int count);
        gost_pkg::t_blk_in  blk;
        gost_pkg::t_blk_out prior;
        logic               have_prior;
        have_prior = 1'b0;
        blk = '0;
        for (int i = 0; i < count; i++) begin
            if (have_prior && $urandom_range(0, 3) == 0) begin
                // round trip: last output goes back in under the other operation
                blk.operation  = ~blk.operation;
                blk.block_low  = prior.result_low;
                blk.block_high = prior.result_high;
            end else begin
                blk.operation  = 1'($urandom_range(0, 1));
                blk.block_low  = rand_half();
                blk.block_high = rand_half();
            end
            prior = gost_crypt(blk);
            have_prior = 1'b1;
            push_block(blk, ((i / 40) % 3 == 1) ? 0 : pick_gap());
        end
        finish_batch();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        blocks_sent  = 0;
        results_seen = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        for (int k = 0; k < gost_pkg::KeyWords; k++) key_words[k] = 32'h0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key reads back as zero after reset, and blocks run under the all-zero key
        for (int k = 0; k < gost_pkg::KeyWords; k++) check_key(k);
        apb_idle();
        run_directed();

        for (int k = 0; k < gost_pkg::KeyWords; k++) key_plan[k] = 32'hFFFF_FFFF;
        program_keys();
        run_directed();

        for (int p = 0; p < KeyPlans; p++) begin
            for (int k = 0; k < gost_pkg::KeyWords; k++) begin
                case (p)
                    0: key_plan[k] = (k % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA;
                    1: key_plan[k] = (k % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                    default: key_plan[k] = rand_half();
                endcase
            end
            program_keys();
            run_random(RandomPerKey);
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- gost_block_cipher_ecb.f -----
rtl/core/gost_pkg.sv
rtl/core/gost_round.sv
rtl/core/gost_block_cipher_ecb.sv
rtl/core/gost_chk.sv
test/tb_top.sv
